>>> rtl/cdq_pkg.sv
package cdq_pkg;

   localparam int DEPTH   = 1024;
   localparam int WIDTH   = 16;
   localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int CAP_W   = 11;
   localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int FUNC_W  = 3;
   localparam int VALUE_W = 16;
   localparam int OUT_W   = 17;

   typedef logic [ADDR_W-1:0]  addr_type;
   typedef logic [WIDTH-1:0]   data_type;
   typedef logic [CNT_W-1:0]   count_type;
   typedef logic [CAP_W-1:0]   cap_type;
   typedef logic [FUNC_W-1:0]  func_code_type;
   typedef logic [VALUE_W-1:0] value_type;
   typedef logic signed [OUT_W-1:0] out_value_type;

   localparam cap_type       CAP_RESET  = cap_type'(1024);
   localparam addr_type      LAST_ADDR  = addr_type'(DEPTH - 1);
   localparam count_type     FULL_COUNT = count_type'(DEPTH);
   localparam out_value_type NONE_VALUE = '1;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH_FRONT = 3'd0,
      FUNC_PUSH_BACK  = 3'd1,
      FUNC_POP_FRONT  = 3'd2,
      FUNC_POP_BACK   = 3'd3,
      FUNC_QUERY      = 3'd4
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_LOAD
   } state_type;

   // outcome of one step, handed from the pointer unit to the top level
   typedef struct packed {
      logic     ok;
      logic     empty;
      logic     full;
      addr_type front_addr;
      addr_type back_addr;
   } step_type;

   function automatic addr_type wrap_inc(input addr_type p);
      addr_type r;
      if (p == LAST_ADDR) r = '0;
      else r = p + addr_type'(1);
      return r;
   endfunction

   function automatic addr_type wrap_dec(input addr_type p);
      addr_type r;
      if (p == '0) r = LAST_ADDR;
      else r = p - addr_type'(1);
      return r;
   endfunction

endpackage

>>> rtl/cdq_if.sv
interface cdq_req_if;
   logic                   valid;
   logic                   ready;
   cdq_pkg::func_code_type func;
   cdq_pkg::value_type     value;
   modport source (output valid, func, value, input ready);
   modport sink   (input valid, func, value, output ready);
endinterface

interface cdq_rsp_if;
   logic                   valid;
   logic                   ready;
   logic                   ok;
   cdq_pkg::out_value_type front_value;
   cdq_pkg::out_value_type back_value;
   logic                   empty_res;
   logic                   full_res;
   modport source (output valid, ok, front_value, back_value, empty_res, full_res,
                   input ready);
   modport sink   (input valid, ok, front_value, back_value, empty_res, full_res,
                   output ready);
endinterface

interface cdq_csr_if;
   logic             valid;
   logic             ready;
   cdq_pkg::cap_type capacity;
   modport source (output valid, capacity, input ready);
   modport sink   (input valid, capacity, output ready);
endinterface

>>> rtl/cdq_ram.sv
module cdq_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 1024,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr_a,
   input  logic [AW-1:0]     rd_addr_b,
   output logic [DATA_W-1:0] rd_data_a,
   output logic [DATA_W-1:0] rd_data_b
);

   logic [DATA_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

>>> rtl/cdq_ptr.sv
module cdq_ptr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step_en,
   input  cdq_pkg::func_code_type func,
   input  cdq_pkg::cap_type       capacity,
   output logic                   wr_en,
   output cdq_pkg::addr_type      wr_addr,
   output cdq_pkg::step_type      step
);

   cdq_pkg::addr_type  head_ff, head_in;
   cdq_pkg::addr_type  tail_ff, tail_in;
   cdq_pkg::count_type count_ff, count_in;
   cdq_pkg::step_type  step_ff, step_in;

   logic                         full_now;
   logic                         empty_now;
   logic                         ok;
   logic [cdq_pkg::CMP_W-1:0]    cap_cmp;

   always_comb begin
      cap_cmp   = cdq_pkg::CMP_W'(capacity);
      // the count never exceeds DEPTH, so reaching DEPTH caps a larger register
      full_now  = (cdq_pkg::CMP_W'(count_ff) >= cap_cmp) || (count_ff == cdq_pkg::FULL_COUNT);
      empty_now = (count_ff == '0);
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      ok        = 1'b1;
      wr_en     = 1'b0;
      wr_addr   = tail_ff;

      unique case (cdq_pkg::func_type'(func))
         cdq_pkg::FUNC_PUSH_FRONT: begin
            if (full_now) begin
               ok = 1'b0;
            end else begin
               head_in  = cdq_pkg::wrap_dec(head_ff);
               wr_en    = step_en;
               wr_addr  = head_in;
               count_in = count_ff + cdq_pkg::count_type'(1);
            end
         end
         cdq_pkg::FUNC_PUSH_BACK: begin
            if (full_now) begin
               ok = 1'b0;
            end else begin
               wr_en    = step_en;
               tail_in  = cdq_pkg::wrap_inc(tail_ff);
               count_in = count_ff + cdq_pkg::count_type'(1);
            end
         end
         cdq_pkg::FUNC_POP_FRONT: begin
            if (empty_now) begin
               ok = 1'b0;
            end else begin
               head_in  = cdq_pkg::wrap_inc(head_ff);
               count_in = count_ff - cdq_pkg::count_type'(1);
            end
         end
         cdq_pkg::FUNC_POP_BACK: begin
            if (empty_now) begin
               ok = 1'b0;
            end else begin
               tail_in  = cdq_pkg::wrap_dec(tail_ff);
               count_in = count_ff - cdq_pkg::count_type'(1);
            end
         end
         default: begin
            // query and unused codes leave everything in place
         end
      endcase

      step_in.ok         = ok;
      step_in.empty      = (count_in == '0);
      step_in.full       = (cdq_pkg::CMP_W'(count_in) >= cap_cmp) ||
                           (count_in == cdq_pkg::FULL_COUNT);
      step_in.front_addr = head_in;
      step_in.back_addr  = cdq_pkg::wrap_dec(tail_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (step_en) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en) begin
         step_ff <= step_in;
      end
   end

   assign step = step_ff;

endmodule

>>> rtl/circular_deque_core.sv
// Bounded double-ended queue of WIDTH-bit elements kept in a DEPTH-entry ring
// memory. Each request word inserts at the front or back, deletes from the
// front or back, or only queries (codes above query act as a query). The
// response word gives ok, the front and back elements after the step (all
// ones, i.e. -1, when empty) and the empty/full flags after the step. From
// acceptance to a valid response, the accept cycle updates the pointers and
// writes the memory, the read state reads the front and back entries through
// the memory's two read ports, and the load state loads the response register
// once the previous response has been taken. Only one step is outstanding: no
// new word is taken until the previous one has loaded its response. A new
// request is taken while the previous response still waits. The capacity
// register (reset 1024, capped in effect at DEPTH) is written through the csr
// port, is always ready, and must only change while the block is idle;
// lowering it below the current count leaves the held elements readable.
module circular_deque_core (
   input  logic      clock,
   input  logic      reset,
   cdq_req_if.sink   req_bus,
   cdq_rsp_if.source rsp_bus,
   cdq_csr_if.sink   csr_bus
);

   cdq_pkg::state_type state_ff, state_in;
   cdq_pkg::cap_type   capacity_ff;
   cdq_pkg::step_type  step;

   logic               step_en;
   logic               wr_en;
   cdq_pkg::addr_type  wr_addr;
   logic               rd_en;
   cdq_pkg::data_type  rd_front;
   cdq_pkg::data_type  rd_back;
   logic               load_rsp;

   logic                   rsp_valid_ff;
   logic                   rsp_ok_ff;
   cdq_pkg::out_value_type rsp_front_ff;
   cdq_pkg::out_value_type rsp_back_ff;
   logic                   rsp_empty_ff;
   logic                   rsp_full_ff;

   // capacity register: always ready; writing it only while idle is left to the user
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= cdq_pkg::CAP_RESET;
      end else if (csr_bus.valid) begin
         capacity_ff <= csr_bus.capacity;
      end
   end

   assign req_bus.ready = (state_ff == cdq_pkg::ST_IDLE);
   assign step_en       = req_bus.valid && req_bus.ready;

   // pointers, count and per-step flags
   cdq_ptr u_ptr (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .func     (req_bus.func),
      .capacity (capacity_ff),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .step     (step)
   );

   // ring memory: write at accept, read front and back in the following cycle
   cdq_ram #(
      .DATA_W (cdq_pkg::WIDTH),
      .DEPTH  (cdq_pkg::DEPTH)
   ) u_ram (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (cdq_pkg::data_type'(req_bus.value)),
      .rd_en     (rd_en),
      .rd_addr_a (step.front_addr),
      .rd_addr_b (step.back_addr),
      .rd_data_a (rd_front),
      .rd_data_b (rd_back)
   );

   // sequencer: accept, read, load response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cdq_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      rd_en    = 1'b0;
      load_rsp = 1'b0;
      unique case (state_ff)
         cdq_pkg::ST_IDLE: begin
            if (step_en) state_in = cdq_pkg::ST_READ;
         end
         cdq_pkg::ST_READ: begin
            rd_en    = 1'b1;
            state_in = cdq_pkg::ST_LOAD;
         end
         cdq_pkg::ST_LOAD: begin
            // hold the read data until the response register frees up
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load_rsp = 1'b1;
               state_in = cdq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cdq_pkg::ST_IDLE;
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_ok_ff    <= step.ok;
         rsp_empty_ff <= step.empty;
         rsp_full_ff  <= step.full;
         // substitute -1 when empty: the addressed entries hold no live element
         if (step.empty) begin
            rsp_front_ff <= cdq_pkg::NONE_VALUE;
            rsp_back_ff  <= cdq_pkg::NONE_VALUE;
         end else begin
            rsp_front_ff <= cdq_pkg::out_value_type'(rd_front);
            rsp_back_ff  <= cdq_pkg::out_value_type'(rd_back);
         end
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.ok          = rsp_ok_ff;
   assign rsp_bus.front_value = rsp_front_ff;
   assign rsp_bus.back_value  = rsp_back_ff;
   assign rsp_bus.empty_res   = rsp_empty_ff;
   assign rsp_bus.full_res    = rsp_full_ff;

endmodule

>>> rtl/cdq_checker.sv
module cdq_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input cdq_pkg::out_value_type front_value,
   input cdq_pkg::out_value_type back_value,
   input logic                   empty_res
);

   // a stalled response word holds its contents
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(front_value) && $stable(back_value)
      && $stable(empty_res))
      else $error("response changed while stalled");

   // an empty deque reports -1 at both ends
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && empty_res |-> front_value == cdq_pkg::NONE_VALUE &&
      back_value == cdq_pkg::NONE_VALUE)
      else $error("empty response without -1 values");

   // one step at a time: the request side closes right after an accept
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a step is in flight");

   // a response does not rise while its step is still in the read state
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response rose too early");

endmodule

bind circular_deque_core cdq_checker u_cdq_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .front_value (rsp_bus.front_value),
   .back_value  (rsp_bus.back_value),
   .empty_res   (rsp_bus.empty_res)
);
